@@ sv/ppc_alu_pkg.sv @@
package ppc_alu_pkg;

  typedef enum logic [4:0] {
    OP_ADDI   = 5'd0,
    OP_ADDIS  = 5'd1,
    OP_ADD    = 5'd2,
    OP_SUBF   = 5'd3,
    OP_ADDIC  = 5'd4,
    OP_SUBFIC = 5'd5,
    OP_ADDC   = 5'd6,
    OP_SUBFC  = 5'd7,
    OP_ADDE   = 5'd8,
    OP_SUBFE  = 5'd9,
    OP_ADDME  = 5'd10,
    OP_SUBFME = 5'd11,
    OP_ADDZE  = 5'd12,
    OP_SUBFZE = 5'd13,
    OP_NEG    = 5'd14,
    OP_MULLI  = 5'd15,
    OP_MULLW  = 5'd16,
    OP_MULHW  = 5'd17,
    OP_MULHWU = 5'd18,
    OP_DIVW   = 5'd19,
    OP_DIVWU  = 5'd20
  } op_t;

  localparam int WordW = 32;
  localparam int HalfW = 16;

  // request to the shared multiply/divide unit
  typedef struct packed {
    logic             start;
    logic             is_div;
    logic [WordW-1:0] x;
    logic [WordW-1:0] y;
  } md_req_t;

  typedef struct packed {
    logic               done;
    logic [2*WordW-1:0] prod;
    logic [WordW-1:0]   quot;
  } md_rsp_t;

endpackage

@@ sv/ppc32_integer_alu.sv @@
// PowerPC 32-bit integer ALU.
// Input stream s_axis: one beat per instruction (fields in s_axis_tdata).
// Output stream m_axis: one beat per instruction with result, write enable,
// CR0 image and the XER CA/OV/SO bits after the instruction.
// Add/subtract forms: after accept the block steps through S_EXEC and S_OUT,
// where the output beat is registered.
// Multiply and divide forms run a shared one-bit-per-cycle shift/add unit:
// the start request, the operand load, 32 iterations, the done flag and the
// output register lie between accept and the output beat.
// One instruction is in flight at a time; s_axis_tready is low until the
// output beat has been taken.
// If the receiver holds m_axis_tready low, the result stays registered on
// m_axis and nothing new is accepted.
// Reset clears XER CA, OV and SO and empties the block.
module ppc32_integer_alu (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [4:0] action, [36:5] a_value, [68:37] b_value, [84:69] immediate,
  // [85] a_is_zero_reg, [86] record, [87] overflow_enable
  input  logic [87:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] result, [32] write_result, [36:33] cr0_bits, [37] cr0_valid,
  // [38] carry_out, [39] overflow_out, [40] summary_overflow_out
  output logic [47:0]  m_axis_tdata
);
  import ppc_alu_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_MD, S_OUT} state_t;

  state_t            state;
  logic [4:0]        act;
  logic [WordW-1:0]  a, b, simm;
  logic              azero, rec, oe;
  logic              ca, ov, so;
  logic              neg_res, is_hi;
  logic              is_md;
  md_req_t           req;
  md_rsp_t           rsp;

  logic [WordW-1:0]  r;
  logic              cy, ovc, wr, rc_ok, sets_ca, ov_form;
  logic [WordW:0]    s33;
  logic [WordW-1:0]  ma, mb, mres;
  logic              na, nb, signed_op;
  logic [2*WordW-1:0] pfix;
  logic [WordW-1:0]  qfix;
  logic              ca_n, ov_n, so_n;
  logic [3:0]        crb;

  ppc_alu_md u_md (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  assign s_axis_tready = (state == S_IDLE);
  assign is_md = act inside {[OP_MULLI:OP_DIVWU]};

  // operands for the shared unit; magnitudes for the signed forms MULHW and DIVW
  always_comb begin
    signed_op = (act == OP_MULHW) || (act == OP_DIVW);
    na = signed_op && a[WordW-1];
    nb = signed_op && b[WordW-1];
    ma = na ? (WordW'(0) - a) : a;
    mb = nb ? (WordW'(0) - b) : b;
    if (act == OP_MULLI) mb = simm;
  end

  always_comb begin
    r = '0; cy = 1'b0; ovc = 1'b0; wr = 1'b1; rc_ok = 1'b1;
    sets_ca = 1'b0; ov_form = 1'b0; s33 = '0;
    pfix = neg_res ? ((2*WordW)'(0) - rsp.prod) : rsp.prod;
    qfix = neg_res ? (WordW'(0) - rsp.quot) : rsp.quot;
    mres = is_hi ? pfix[2*WordW-1:WordW] : rsp.prod[WordW-1:0];
    case (act)
      OP_ADDI:   begin r = (azero ? '0 : a) + simm; rc_ok = 1'b0; end
      OP_ADDIS:  begin r = (azero ? '0 : a) + {simm[HalfW-1:0], {HalfW{1'b0}}};
                       rc_ok = 1'b0; end
      OP_ADD, OP_ADDC: begin
        s33 = {1'b0, a} + {1'b0, b};
        sets_ca = (act == OP_ADDC);
        ov_form = 1'b1;
      end
      OP_SUBF, OP_SUBFC: begin
        s33 = {1'b0, ~a} + {1'b0, b} + 33'd1;
        sets_ca = (act == OP_SUBFC);
        ov_form = (act == OP_SUBF);
      end
      OP_ADDIC:  begin s33 = {1'b0, a} + {1'b0, simm}; sets_ca = 1'b1; end
      OP_SUBFIC: begin s33 = {1'b0, ~a} + {1'b0, simm} + 33'd1;
                       sets_ca = 1'b1; rc_ok = 1'b0; end
      OP_ADDE:   begin s33 = {1'b0, a} + {1'b0, b} + {32'd0, ca}; sets_ca = 1'b1; end
      OP_SUBFE:  begin s33 = {1'b0, ~a} + {1'b0, b} + {32'd0, ca}; sets_ca = 1'b1; end
      OP_ADDME:  begin s33 = {1'b0, a} + {1'b0, {WordW{1'b1}}} + {32'd0, ca};
                       sets_ca = 1'b1; end
      OP_SUBFME: begin s33 = {1'b0, ~a} + {1'b0, {WordW{1'b1}}} + {32'd0, ca};
                       sets_ca = 1'b1; end
      OP_ADDZE:  begin s33 = {1'b0, a} + {32'd0, ca}; sets_ca = 1'b1; end
      OP_SUBFZE: begin s33 = {1'b0, ~a} + {32'd0, ca}; sets_ca = 1'b1; end
      OP_NEG:    r = WordW'(0) - a;
      OP_MULLI:  begin r = mres; rc_ok = 1'b0; end
      OP_MULLW, OP_MULHW, OP_MULHWU: r = mres;
      OP_DIVW:   begin
        wr = (b != '0) && !(a == 32'h8000_0000 && b == 32'hFFFF_FFFF);
        r = qfix;
      end
      OP_DIVWU:  begin wr = (b != '0); r = rsp.quot; end
      default:   wr = 1'b0;
    endcase
    if (s33 != '0 || act inside {[OP_ADD:OP_SUBFZE]}) begin
      if (act inside {[OP_ADD:OP_SUBFZE]}) begin
        r  = s33[WordW-1:0];
        cy = s33[WordW];
      end
    end
    if (act == OP_SUBF)
      ovc = (~a[WordW-1] ^ r[WordW-1]) & (b[WordW-1] ^ r[WordW-1]);
    else
      ovc = (a[WordW-1] ^ r[WordW-1]) & (b[WordW-1] ^ r[WordW-1]);
    if (!wr) r = '0;
    ca_n = (sets_ca && wr) ? cy : ca;
    ov_n = ov; so_n = so;
    if (ov_form && oe && wr) begin
      ov_n = ovc;
      so_n = so | ovc;
    end
    crb = '0;
    if (wr && rec && rc_ok) begin
      crb[3] = r[WordW-1];
      crb[2] = !r[WordW-1] && (r != '0);
      crb[1] = (r == '0);
      crb[0] = so_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      req.start     <= 1'b0;
      ca <= 1'b0; ov <= 1'b0; so <= 1'b0;
    end else begin
      req.start <= (state == S_EXEC) && is_md;
      case (state)
        S_IDLE: if (s_axis_tvalid) begin
          act   <= s_axis_tdata[4:0];
          a     <= s_axis_tdata[36:5];
          b     <= s_axis_tdata[68:37];
          simm  <= {{HalfW{s_axis_tdata[84]}}, s_axis_tdata[84:69]};
          azero <= s_axis_tdata[85];
          rec   <= s_axis_tdata[86];
          oe    <= s_axis_tdata[87];
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (is_md) begin
            req.is_div <= (act == OP_DIVW) || (act == OP_DIVWU);
            req.x      <= ma;
            req.y      <= mb;
            neg_res    <= na ^ nb ^ ((act == OP_MULLI) ? (a[WordW-1] ^ simm[WordW-1]) : 1'b0);
            is_hi      <= (act == OP_MULHW) || (act == OP_MULHWU);
            state      <= S_MD;
          end else begin
            state <= S_OUT;
          end
        end
        S_MD: if (rsp.done) state <= S_OUT;
        S_OUT: begin
          if (!m_axis_tvalid) begin
            m_axis_tdata  <= {7'd0, so_n, ov_n, ca_n, (wr && rec && rc_ok), crb, wr, r};
            m_axis_tvalid <= 1'b1;
            ca <= ca_n; ov <= ov_n; so <= so_n;
          end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/ppc_alu_md.sv @@
// Shared unsigned shift/add unit: multiply or restoring divide, one bit per cycle.
module ppc_alu_md (
  input  logic                clk,
  input  logic                rst,
  input  ppc_alu_pkg::md_req_t req,
  output ppc_alu_pkg::md_rsp_t rsp
);
  import ppc_alu_pkg::*;

  logic                 busy;
  logic                 done;
  logic                 div_mode;
  logic [5:0]           cnt;
  logic [WordW-1:0]     y;
  logic [2*WordW-1:0]   acc;
  logic [WordW:0]       sum;
  logic [WordW:0]       diff;

  assign sum  = {1'b0, acc[2*WordW-1:WordW]} + (acc[0] ? {1'b0, y} : '0);
  assign diff = {acc[2*WordW-1:WordW-1]} - {1'b0, y};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !req.start && busy && (cnt == 6'(WordW - 1));
      if (req.start) begin
        busy     <= 1'b1;
        div_mode <= req.is_div;
        y        <= req.y;
        acc      <= {{WordW{1'b0}}, req.x};
        cnt      <= '0;
      end else if (busy) begin
        if (div_mode) begin
          if (!diff[WordW])
            acc <= {diff[WordW-1:0], acc[WordW-2:0], 1'b1};
          else
            acc <= {acc[2*WordW-2:0], 1'b0};
        end else begin
          acc <= {sum, acc[WordW-1:1]};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'(WordW - 1))
          busy <= 1'b0;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.prod = acc;
  assign rsp.quot = acc[WordW-1:0];

endmodule

@@ sv/ppc_alu_checker.sv @@
module ppc_alu_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);
  // never accepting while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input ready while output pending");
  // sticky SO never drops without reset
  a_so_sticky: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tdata[40]) |=>
      ((m_axis_tvalid && m_axis_tready) [->1] |-> m_axis_tdata[40]))
    else $error("so");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("output changed under stall");
  // no write means zeroed result and no CR0
  a_nowrite: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[32]) |->
      (m_axis_tdata[31:0] == 32'd0 && !m_axis_tdata[37]))
    else $error("suppressed write carries data");
endmodule

bind ppc32_integer_alu ppc_alu_checker u_chk (
  .clk(clk), .rst(rst),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
